[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands used by lru_page_buffer_pool.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset
`define LPBP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true outside reset
`define LPBP_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   `LPBP_ASSERT(lbl, clk, rst, !(expr), msg)

`endif

[rtl/core/lpbp_pkg.sv]
// ----------------------------------------------------------------------------
// lpbp_pkg
// Request and status codes and command bundles for the page buffer pool.
// ----------------------------------------------------------------------------
package lpbp_pkg;

   localparam logic [1:0] REQ_GET   = 2'd0;
   localparam logic [1:0] REQ_DIRTY = 2'd1;
   localparam logic [1:0] REQ_DROP  = 2'd2;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_ZERO  = 2'd2;

   // page table write command
   typedef struct packed {
      logic map_we;
      logic map_res;
      logic dirty_we;
      logic dirty_val;
   } pt_cmd_type;

   // frame store write command
   typedef struct packed {
      logic tag_we;
      logic dirty_we;
      logic dirty_val;
      logic prev_we;
      logic next_we;
   } fs_cmd_type;

endpackage

[rtl/core/lpbp_page_table.sv]
// ----------------------------------------------------------------------------
// lpbp_page_table
// Page-to-frame map and per-page dirty marks, with a clearing pass after reset.
// ----------------------------------------------------------------------------
module lpbp_page_table #(
   parameter int MAX_PAGES = 1024,
   parameter int FRAME_W = 4,
   localparam int PW = $clog2(MAX_PAGES)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rd_en,
   input  logic [PW-1:0]          rd_addr,
   output logic                   rd_res,
   output logic [FRAME_W-1:0]     rd_frame,
   output logic                   rd_dirty,
   input  lpbp_pkg::pt_cmd_type   wr_cmd,
   input  logic [PW-1:0]          wr_addr,
   input  logic [FRAME_W-1:0]     wr_frame,
   output logic                   clearing
);
   import lpbp_pkg::*;

   logic [FRAME_W:0] map_mem [MAX_PAGES];
   logic             dirty_mem [MAX_PAGES];
   logic [FRAME_W:0] map_rd_ff;
   logic             dirty_rd_ff;
   logic [PW:0]      clr_ff;
   logic [PW:0]      clr_in;

   assign clearing = (clr_ff < (PW+1)'(MAX_PAGES));
   assign clr_in   = clearing ? clr_ff + 1'b1 : clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   // sweep zeros through both stores until the pass completes
   always_ff @(posedge clock) begin
      if (clearing) begin
         map_mem[clr_ff[PW-1:0]]   <= '0;
         dirty_mem[clr_ff[PW-1:0]] <= 1'b0;
      end else begin
         if (wr_cmd.map_we) begin
            map_mem[wr_addr] <= {wr_cmd.map_res, wr_frame};
         end
         if (wr_cmd.dirty_we) begin
            dirty_mem[wr_addr] <= wr_cmd.dirty_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         map_rd_ff   <= map_mem[rd_addr];
         dirty_rd_ff <= dirty_mem[rd_addr];
      end
   end

   assign rd_res   = map_rd_ff[FRAME_W];
   assign rd_frame = map_rd_ff[FRAME_W-1:0];
   assign rd_dirty = dirty_rd_ff;

endmodule

[rtl/core/lpbp_frame_store.sv]
// ----------------------------------------------------------------------------
// lpbp_frame_store
// Per-frame page tag, dirty bit and recency links.
// ----------------------------------------------------------------------------
module lpbp_frame_store #(
   parameter int POOL_FRAMES = 16,
   parameter int PW = 10,
   localparam int FW = $clog2(POOL_FRAMES)
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [FW-1:0]        rd_addr,
   output logic [PW-1:0]        rd_tag,
   output logic                 rd_dirty,
   output logic [FW:0]          rd_prev,
   output logic [FW:0]          rd_next,
   input  lpbp_pkg::fs_cmd_type wr_cmd,
   input  logic [FW-1:0]        wr_addr,
   input  logic [PW-1:0]        wr_tag,
   input  logic [FW-1:0]        prev_addr,
   input  logic [FW:0]          prev_data,
   input  logic [FW-1:0]        next_addr,
   input  logic [FW:0]          next_data
);
   import lpbp_pkg::*;

   logic [PW-1:0] tag_mem [POOL_FRAMES];
   logic          dirty_mem [POOL_FRAMES];
   logic [FW:0]   prev_mem [POOL_FRAMES];
   logic [FW:0]   next_mem [POOL_FRAMES];

   always_ff @(posedge clock) begin
      if (wr_cmd.tag_we) begin
         tag_mem[wr_addr] <= wr_tag;
      end
      if (wr_cmd.dirty_we) begin
         dirty_mem[wr_addr] <= wr_cmd.dirty_val;
      end
      if (wr_cmd.prev_we) begin
         prev_mem[prev_addr] <= prev_data;
      end
      if (wr_cmd.next_we) begin
         next_mem[next_addr] <= next_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_tag   <= tag_mem[rd_addr];
         rd_dirty <= dirty_mem[rd_addr];
         rd_prev  <= prev_mem[rd_addr];
         rd_next  <= next_mem[rd_addr];
      end
   end

endmodule

[rtl/core/lru_page_buffer_pool.sv]
// ----------------------------------------------------------------------------
// lru_page_buffer_pool
// Buffer pool bookkeeping: page map, dirty marks and LRU order of frames.
// ----------------------------------------------------------------------------
// After reset the block sweeps all MAX_PAGES page table entries with busy
// high. A transaction is taken when start is high and busy low; exactly one
// result follows, shown for a single cycle with rsp_valid, and the receiver
// must take it then. Out-of-range pages, drops of page zero and unknown
// requests answer in the cycle after acceptance; other requests go through
// the registered page table read in S_LOOK and, as needed, a frame store
// read and link writes in the S_UNLINK, S_INSERT and S_LINK sequencer states.
module lru_page_buffer_pool #(
   parameter int POOL_FRAMES = 16,
   parameter int MAX_PAGES = 1024,
   localparam int FW = $clog2(POOL_FRAMES),
   localparam int PW = $clog2(MAX_PAGES)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  logic [1:0]    req_type,
   input  logic [PW-1:0] req_page_number,
   output logic          rsp_valid,
   output logic [1:0]    rsp_status,
   output logic          rsp_hit,
   output logic [FW-1:0] rsp_frame_index,
   output logic          rsp_victim_valid,
   output logic [PW-1:0] rsp_evicted_page,
   output logic          rsp_victim_writeback,
   output logic          rsp_fetch_needed,
   output logic [31:0]   rsp_hit_count,
   output logic [31:0]   rsp_miss_count,
   output logic [31:0]   rsp_eviction_count
);
   import lpbp_pkg::*;
   `include "assert_macros.svh"

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LOOK   = 3'd1;
   localparam logic [2:0] S_UNLINK = 3'd2;
   localparam logic [2:0] S_INSERT = 3'd3;
   localparam logic [2:0] S_LINK   = 3'd4;

   localparam logic [FW:0] NIL = (FW+1)'(POOL_FRAMES);

   logic [2:0]             state_ff, state_in;
   logic [1:0]             type_ff, type_in;
   logic [PW-1:0]          page_ff, page_in;
   logic [FW-1:0]          f_ff, f_in;
   logic                   evict_ff, evict_in;
   logic [FW:0]            front_ff, front_in;
   logic [FW:0]            back_ff, back_in;
   logic [FW:0]            ofront_ff, ofront_in;
   logic [POOL_FRAMES-1:0] used_ff, used_in;
   logic                   valid_ff, valid_in;
   logic [1:0]             status_ff, status_in;
   logic                   hit_ff, hit_in;
   logic [FW-1:0]          frame_ff, frame_in;
   logic                   vvalid_ff, vvalid_in;
   logic [PW-1:0]          vpage_ff, vpage_in;
   logic                   vwb_ff, vwb_in;
   logic                   fetch_ff, fetch_in;
   logic [31:0]            hits_ff, hits_in;
   logic [31:0]            misses_ff, misses_in;
   logic [31:0]            evicts_ff, evicts_in;

   logic          accept;
   logic          clearing;
   logic          pt_res;
   logic [FW-1:0] pt_frame;
   logic          pt_dirty;
   pt_cmd_type    pt_cmd;
   logic [PW-1:0] pt_wr_addr;
   logic [FW-1:0] pt_wr_frame;
   logic          fs_rd_en;
   logic [FW-1:0] fs_rd_addr;
   logic [PW-1:0] fs_tag;
   logic          fs_dirty;
   logic [FW:0]   fs_prev;
   logic [FW:0]   fs_next;
   fs_cmd_type    fs_cmd;
   logic [FW-1:0] fs_wr_addr;
   logic [FW-1:0] fs_prev_addr;
   logic [FW:0]   fs_prev_data;
   logic [FW-1:0] fs_next_addr;
   logic [FW:0]   fs_next_data;
   logic          free_found;
   logic [FW-1:0] free_idx;
   logic [FW-1:0] vict_idx;

   assign busy   = clearing || (state_ff != S_IDLE);
   assign accept = start && !busy;

   lpbp_page_table #(
      .MAX_PAGES (MAX_PAGES),
      .FRAME_W   (FW)
   ) u_page_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (req_page_number),
      .rd_res   (pt_res),
      .rd_frame (pt_frame),
      .rd_dirty (pt_dirty),
      .wr_cmd   (pt_cmd),
      .wr_addr  (pt_wr_addr),
      .wr_frame (pt_wr_frame),
      .clearing (clearing)
   );

   lpbp_frame_store #(
      .POOL_FRAMES (POOL_FRAMES),
      .PW          (PW)
   ) u_frame_store (
      .clock     (clock),
      .rd_en     (fs_rd_en),
      .rd_addr   (fs_rd_addr),
      .rd_tag    (fs_tag),
      .rd_dirty  (fs_dirty),
      .rd_prev   (fs_prev),
      .rd_next   (fs_next),
      .wr_cmd    (fs_cmd),
      .wr_addr   (fs_wr_addr),
      .wr_tag    (page_ff),
      .prev_addr (fs_prev_addr),
      .prev_data (fs_prev_data),
      .next_addr (fs_next_addr),
      .next_data (fs_next_data)
   );

   // lowest-numbered empty frame
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = POOL_FRAMES - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_idx   = FW'(i);
         end
      end
   end

   assign vict_idx = (back_ff != NIL) ? back_ff[FW-1:0] : '0;

   always_comb begin
      state_in     = state_ff;
      type_in      = type_ff;
      page_in      = page_ff;
      f_in         = f_ff;
      evict_in     = evict_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      ofront_in    = ofront_ff;
      used_in      = used_ff;
      valid_in     = 1'b0;
      status_in    = status_ff;
      hit_in       = hit_ff;
      frame_in     = frame_ff;
      vvalid_in    = vvalid_ff;
      vpage_in     = vpage_ff;
      vwb_in       = vwb_ff;
      fetch_in     = fetch_ff;
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      evicts_in    = evicts_ff;
      pt_cmd       = '0;
      pt_wr_addr   = page_ff;
      pt_wr_frame  = '0;
      fs_rd_en     = 1'b0;
      fs_rd_addr   = f_ff;
      fs_cmd       = '0;
      fs_wr_addr   = f_ff;
      fs_prev_addr = f_ff;
      fs_prev_data = NIL;
      fs_next_addr = f_ff;
      fs_next_data = NIL;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               type_in   = req_type;
               page_in   = req_page_number;
               status_in = STAT_OK;
               hit_in    = 1'b0;
               frame_in  = '0;
               vvalid_in = 1'b0;
               vpage_in  = '0;
               vwb_in    = 1'b0;
               fetch_in  = 1'b0;
               if ({1'b0, req_page_number} >= (PW+1)'(MAX_PAGES)) begin
                  status_in = STAT_RANGE;
                  valid_in  = 1'b1;
               end else if (req_type == REQ_DROP && req_page_number == '0) begin
                  status_in = STAT_ZERO;
                  valid_in  = 1'b1;
               end else if (req_type inside {REQ_GET, REQ_DIRTY, REQ_DROP}) begin
                  state_in = S_LOOK;
               end else begin
                  valid_in = 1'b1;
               end
            end
         end
         S_LOOK: begin
            case (type_ff)
               REQ_GET: begin
                  if (pt_res) begin
                     hits_in  = hits_ff + 1'b1;
                     hit_in   = 1'b1;
                     frame_in = pt_frame;
                     if (front_ff == {1'b0, pt_frame}) begin
                        valid_in = 1'b1;
                        state_in = S_IDLE;
                     end else begin
                        f_in       = pt_frame;
                        evict_in   = 1'b0;
                        fs_rd_en   = 1'b1;
                        fs_rd_addr = pt_frame;
                        state_in   = S_UNLINK;
                     end
                  end else begin
                     misses_in = misses_ff + 1'b1;
                     fetch_in  = 1'b1;
                     if (free_found) begin
                        f_in     = free_idx;
                        state_in = S_INSERT;
                     end else begin
                        f_in       = vict_idx;
                        evict_in   = used_ff[vict_idx];
                        fs_rd_en   = 1'b1;
                        fs_rd_addr = vict_idx;
                        state_in   = S_UNLINK;
                     end
                  end
               end
               REQ_DIRTY: begin
                  pt_cmd.dirty_we  = 1'b1;
                  pt_cmd.dirty_val = 1'b1;
                  if (pt_res) begin
                     frame_in         = pt_frame;
                     fs_cmd.dirty_we  = 1'b1;
                     fs_cmd.dirty_val = 1'b1;
                     fs_wr_addr       = pt_frame;
                  end
                  valid_in = 1'b1;
                  state_in = S_IDLE;
               end
               default: begin
                  // drop
                  pt_cmd.dirty_we  = 1'b1;
                  pt_cmd.dirty_val = 1'b0;
                  if (pt_res) begin
                     frame_in          = pt_frame;
                     pt_cmd.map_we     = 1'b1;
                     pt_cmd.map_res    = 1'b0;
                     used_in[pt_frame] = 1'b0;
                     f_in              = pt_frame;
                     evict_in          = 1'b0;
                     fs_rd_en          = 1'b1;
                     fs_rd_addr        = pt_frame;
                     state_in          = S_UNLINK;
                  end else begin
                     valid_in = 1'b1;
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         S_UNLINK: begin
            // splice the frame out of the order
            if (fs_prev != NIL) begin
               fs_cmd.next_we = 1'b1;
               fs_next_addr   = fs_prev[FW-1:0];
               fs_next_data   = fs_next;
            end else if (front_ff == {1'b0, f_ff}) begin
               front_in = fs_next;
            end
            if (fs_next != NIL) begin
               fs_cmd.prev_we = 1'b1;
               fs_prev_addr   = fs_next[FW-1:0];
               fs_prev_data   = fs_prev;
            end else if (back_ff == {1'b0, f_ff}) begin
               back_in = fs_prev;
            end
            if (evict_ff) begin
               vvalid_in      = 1'b1;
               vpage_in       = fs_tag;
               vwb_in         = fs_dirty;
               evicts_in      = evicts_ff + 1'b1;
               pt_cmd.map_we  = 1'b1;
               pt_cmd.map_res = 1'b0;
               pt_wr_addr     = fs_tag;
            end
            if (type_ff == REQ_GET) begin
               state_in = S_INSERT;
            end else begin
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_INSERT: begin
            if (fetch_ff) begin
               fs_cmd.tag_we    = 1'b1;
               fs_cmd.dirty_we  = 1'b1;
               fs_cmd.dirty_val = pt_dirty;
               pt_cmd.map_we    = 1'b1;
               pt_cmd.map_res   = 1'b1;
               pt_wr_frame      = f_ff;
               used_in[f_ff]    = 1'b1;
            end
            frame_in       = f_ff;
            fs_cmd.next_we = 1'b1;
            fs_next_data   = front_ff;
            fs_cmd.prev_we = 1'b1;
            fs_prev_data   = NIL;
            ofront_in      = front_ff;
            front_in       = {1'b0, f_ff};
            if (back_ff == NIL) begin
               back_in = {1'b0, f_ff};
            end
            if (front_ff != NIL) begin
               state_in = S_LINK;
            end else begin
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_LINK: begin
            fs_cmd.prev_we = 1'b1;
            fs_prev_addr   = ofront_ff[FW-1:0];
            fs_prev_data   = {1'b0, f_ff};
            valid_in       = 1'b1;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         front_ff  <= NIL;
         back_ff   <= NIL;
         used_ff   <= '0;
         valid_ff  <= 1'b0;
         hits_ff   <= '0;
         misses_ff <= '0;
         evicts_ff <= '0;
      end else begin
         state_ff  <= state_in;
         front_ff  <= front_in;
         back_ff   <= back_in;
         used_ff   <= used_in;
         valid_ff  <= valid_in;
         hits_ff   <= hits_in;
         misses_ff <= misses_in;
         evicts_ff <= evicts_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff   <= type_in;
      page_ff   <= page_in;
      f_ff      <= f_in;
      evict_ff  <= evict_in;
      ofront_ff <= ofront_in;
      status_ff <= status_in;
      hit_ff    <= hit_in;
      frame_ff  <= frame_in;
      vvalid_ff <= vvalid_in;
      vpage_ff  <= vpage_in;
      vwb_ff    <= vwb_in;
      fetch_ff  <= fetch_in;
   end

   assign rsp_valid            = valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_hit              = hit_ff;
   assign rsp_frame_index      = frame_ff;
   assign rsp_victim_valid     = vvalid_ff;
   assign rsp_evicted_page     = vpage_ff;
   assign rsp_victim_writeback = vwb_ff;
   assign rsp_fetch_needed     = fetch_ff;
   assign rsp_hit_count        = hits_ff;
   assign rsp_miss_count       = misses_ff;
   assign rsp_eviction_count   = evicts_ff;

   `LPBP_ASSERT(a_rsp_idle, clock, reset, valid_ff |-> (state_ff == S_IDLE), "result outside idle")
   `LPBP_ASSERT(a_ends_match, clock, reset, ((front_ff == NIL) == (back_ff == NIL)), "LRU ends disagree")
   `LPBP_ASSERT(a_accept_progress, clock, reset, accept |=> (busy || valid_ff), "transaction lost")
   `LPBP_ASSERT_NEVER(a_hit_fetch, clock, reset, valid_ff && hit_ff && fetch_ff, "hit with fetch")

endmodule

[sim/lru_page_buffer_pool_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_page_buffer_pool_tb
// Drives get, mark-dirty, drop and unknown transactions into the page buffer pool with
// random gaps. An in-bench model of the page map, dirty marks and LRU order
// predicts each result, and every strobed result is checked field by field.
// ----------------------------------------------------------------------------
module lru_page_buffer_pool_tb;
   import lpbp_pkg::*;

   localparam int FRAMES = 16;
   localparam int PAGES = 1024;
   localparam logic [4:0] NONE = 5'd16;
   localparam logic [1:0] REQ_BAD = 2'd3;

   typedef struct {
      logic [1:0]  status;
      logic        hit;
      logic [3:0]  frame;
      logic        vvalid;
      logic [9:0]  vpage;
      logic        vwb;
      logic        fetch;
      logic [31:0] hits;
      logic [31:0] misses;
      logic [31:0] evicts;
   } pool_rsp_type;

   class pool_scoreboard;
      bit         resident[PAGES];
      logic [3:0] map[PAGES];
      bit         pdirty[PAGES];
      bit         used[FRAMES];
      logic [9:0] tag[FRAMES];
      bit         fdirty[FRAMES];
      logic [4:0] prv[FRAMES];
      logic [4:0] nxt[FRAMES];
      logic [4:0] front, back;
      logic [31:0] hits, misses, evicts;
      pool_rsp_type pending[$];
      int         errors, gets, hit_seen, evict_seen, wb_seen;

      function new();
         for (int i = 0; i < FRAMES; i++) begin
            prv[i] = NONE;
            nxt[i] = NONE;
         end
         front = NONE;
         back = NONE;
         hits = 0;
         misses = 0;
         evicts = 0;
      endfunction

      function void unlink(logic [4:0] f);
         logic [4:0] p, n;
         p = prv[f];
         n = nxt[f];
         if (p != NONE) nxt[p] = n;
         else if (front == f) front = n;
         if (n != NONE) prv[n] = p;
         else if (back == f) back = p;
         prv[f] = NONE;
         nxt[f] = NONE;
      endfunction

      function void to_front(logic [4:0] f);
         if (front == f) return;
         unlink(f);
         nxt[f] = front;
         prv[f] = NONE;
         if (front != NONE) prv[front] = f;
         front = f;
         if (back == NONE) back = f;
      endfunction

      // work out the result of one accepted transaction and queue it
      function void note(logic [1:0] req, logic [9:0] page);
         pool_rsp_type r;
         logic [4:0] f;
         r = '{default: '0};
         if (req == REQ_GET) begin
            gets++;
            if (resident[page]) begin
               hits++;
               r.hit = 1;
               r.frame = map[page];
               hit_seen++;
               to_front({1'b0, map[page]});
            end else begin
               misses++;
               r.fetch = 1;
               f = NONE;
               for (int i = FRAMES - 1; i >= 0; i--) if (!used[i]) f = 5'(i);
               if (f == NONE) begin
                  f = (back != NONE) ? back : 5'd0;
                  if (used[f]) begin
                     r.vvalid = 1;
                     r.vpage = tag[f];
                     r.vwb = fdirty[f];
                     resident[tag[f]] = 0;
                     evicts++;
                     evict_seen++;
                     if (fdirty[f]) wb_seen++;
                  end
                  unlink(f);
               end
               used[f] = 1;
               tag[f] = page;
               fdirty[f] = pdirty[page];
               resident[page] = 1;
               map[page] = f[3:0];
               to_front(f);
               r.frame = f[3:0];
            end
         end else if (req == REQ_DIRTY) begin
            pdirty[page] = 1;
            if (resident[page]) begin
               r.frame = map[page];
               fdirty[map[page]] = 1;
            end
         end else if (req == REQ_DROP) begin
            if (page == 0) begin
               r.status = STAT_ZERO;
            end else begin
               if (resident[page]) begin
                  r.frame = map[page];
                  used[map[page]] = 0;
                  fdirty[map[page]] = 0;
                  unlink({1'b0, map[page]});
                  resident[page] = 0;
               end
               pdirty[page] = 0;
            end
         end
         r.hits = hits;
         r.misses = misses;
         r.evicts = evicts;
         pending.push_back(r);
      endfunction

      function void check(pool_rsp_type a);
         pool_rsp_type e;
         if (pending.size() == 0) begin
            $error("result with nothing outstanding");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, a.status); errors++; end
         if (a.hit !== e.hit) begin
            $error("hit exp %0d got %0d", e.hit, a.hit); errors++; end
         if (a.frame !== e.frame) begin
            $error("frame_index exp %0d got %0d", e.frame, a.frame); errors++; end
         if (a.vvalid !== e.vvalid) begin
            $error("victim_valid exp %0d got %0d", e.vvalid, a.vvalid); errors++; end
         if (a.vpage !== e.vpage) begin
            $error("evicted_page exp %0d got %0d", e.vpage, a.vpage); errors++; end
         if (a.vwb !== e.vwb) begin
            $error("victim_writeback exp %0d got %0d", e.vwb, a.vwb); errors++; end
         if (a.fetch !== e.fetch) begin
            $error("fetch_needed exp %0d got %0d", e.fetch, a.fetch); errors++; end
         if (a.hits !== e.hits) begin
            $error("hit_count exp %0d got %0d", e.hits, a.hits); errors++; end
         if (a.misses !== e.misses) begin
            $error("miss_count exp %0d got %0d", e.misses, a.misses); errors++; end
         if (a.evicts !== e.evicts) begin
            $error("eviction_count exp %0d got %0d", e.evicts, a.evicts); errors++; end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_type = REQ_GET;
   logic [9:0]  req_page_number = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic        rsp_hit;
   logic [3:0]  rsp_frame_index;
   logic        rsp_victim_valid;
   logic [9:0]  rsp_evicted_page;
   logic        rsp_victim_writeback;
   logic        rsp_fetch_needed;
   logic [31:0] rsp_hit_count, rsp_miss_count, rsp_eviction_count;

   pool_scoreboard sb = new();
   int sent;

   lru_page_buffer_pool #(.POOL_FRAMES(FRAMES), .MAX_PAGES(PAGES)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_page_number(req_page_number),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_hit(rsp_hit),
      .rsp_frame_index(rsp_frame_index), .rsp_victim_valid(rsp_victim_valid),
      .rsp_evicted_page(rsp_evicted_page), .rsp_victim_writeback(rsp_victim_writeback),
      .rsp_fetch_needed(rsp_fetch_needed), .rsp_hit_count(rsp_hit_count),
      .rsp_miss_count(rsp_miss_count), .rsp_eviction_count(rsp_eviction_count)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         sb.check(pool_rsp_type'{rsp_status, rsp_hit, rsp_frame_index, rsp_victim_valid,
                    rsp_evicted_page, rsp_victim_writeback, rsp_fetch_needed,
                    rsp_hit_count, rsp_miss_count, rsp_eviction_count});
   end

   // hold start high until the block takes the transaction
   task automatic send(logic [1:0] req, logic [9:0] page);
      start <= 1;
      req_type <= req;
      req_page_number <= page;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note(req, page);
      sent++;
   endtask

   task automatic pause();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
      if ($urandom_range(0, 2) == 0) n = 0;
      if (n > 0) begin
         start <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      logic [9:0] base;
      int span, burst, k;
      repeat (11) @(posedge clock);
      reset <= 0;

      // directed: extremes, every request, refusals, fill and evict
      send(REQ_GET, 10'd0);
      send(REQ_GET, 10'd1023);
      send(REQ_DIRTY, 10'd1023);
      send(REQ_GET, 10'd1023);
      send(REQ_DROP, 10'd0);
      send(REQ_BAD, 10'd1023);
      send(REQ_DIRTY, 10'd512);
      send(REQ_DROP, 10'd700);
      for (int i = 1; i <= 15; i++) send(REQ_GET, 10'(i * 33));
      send(REQ_GET, 10'd1022);
      send(REQ_GET, 10'd1023);
      pause();

      while (sent < 1150) begin
         base = 10'($urandom_range(0, 1023));
         span = $urandom_range(0, 3) == 0 ? $urandom_range(17, 40) : $urandom_range(4, 20);
         burst = $urandom_range(10, 60);
         for (int i = 0; i < burst; i++) begin
            k = $urandom_range(0, 19);
            if (k == 0) send(REQ_BAD, 10'($urandom));
            else if (k == 1) send(REQ_DROP, 10'($urandom_range(0, 1) ? 0 : $urandom));
            else if (k == 2) send(REQ_GET, 10'($urandom));
            else if (k < 5) send(REQ_DROP, base + 10'($urandom_range(0, span - 1)));
            else if (k < 8) send(REQ_DIRTY, base + 10'($urandom_range(0, span - 1)));
            else send(REQ_GET, base + 10'($urandom_range(0, span - 1)));
            pause();
         end
      end
      start <= 0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d transactions: %0d gets, %0d hits, %0d evictions (%0d write-backs)",
               sent, sb.gets, sb.hit_seen, sb.evict_seen, sb.wb_seen);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
